// ===== hw/rtl/tksd_pkg.sv =====
// Package for the terminal key sequence decoder: parser state codes, byte codes,
// key codes, the result item type and the shared key table lookup.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tksd_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned KeyWidth    = 5;
   localparam int unsigned ModWidth    = 3;
   localparam int unsigned StateWidth  = 3;
   localparam int unsigned DigitWidth  = 4;
   localparam int unsigned KeyTableLen = 84;

   typedef logic [ByteWidth-1:0]  byte_type;
   typedef logic [KeyWidth-1:0]   key_type;
   typedef logic [ModWidth-1:0]   mod_type;
   typedef logic [StateWidth-1:0] state_type;
   typedef logic [DigitWidth-1:0] digit_type;

   // parser states
   localparam state_type ST_BEGIN = 3'd0;
   localparam state_type ST_ESC   = 3'd1;
   localparam state_type ST_CSI   = 3'd2;
   localparam state_type ST_SS3   = 3'd3;
   localparam state_type ST_MOD   = 3'd4;

   // byte codes
   localparam byte_type CH_TAB   = 8'h09;
   localparam byte_type CH_CR    = 8'h0d;
   localparam byte_type CH_ESC   = 8'h1b;
   localparam byte_type CH_SEMI  = 8'h3b;
   localparam byte_type CH_ZERO  = 8'h30;
   localparam byte_type CH_NINE  = 8'h39;
   localparam byte_type CH_UC_A  = 8'h41;
   localparam byte_type CH_UC_Z  = 8'h5a;
   localparam byte_type CH_LC_A  = 8'h61;
   localparam byte_type CH_LC_Z  = 8'h7a;
   localparam byte_type CH_SS3   = 8'h4f;
   localparam byte_type CH_CSI   = 8'h5b;
   localparam byte_type CH_TILDE = 8'h7e;
   localparam byte_type CH_DEL   = 8'h7f;
   localparam byte_type NumberMax = 8'hff;
   localparam int unsigned NumberRadix = 10;

   // key codes
   localparam key_type KEY_UNKNOWN   = 5'd0;
   localparam key_type KEY_CHAR      = 5'd1;
   localparam key_type KEY_TAB       = 5'd2;
   localparam key_type KEY_BACKSPACE = 5'd3;
   localparam key_type KEY_ENTER     = 5'd4;
   localparam key_type KEY_ESCAPE    = 5'd5;
   localparam key_type KEY_INSERT    = 5'd6;
   localparam key_type KEY_DELETE    = 5'd7;
   localparam key_type KEY_PGUP      = 5'd8;
   localparam key_type KEY_PGDN      = 5'd9;
   localparam key_type KEY_UP        = 5'd10;
   localparam key_type KEY_DOWN      = 5'd11;
   localparam key_type KEY_RIGHT     = 5'd12;
   localparam key_type KEY_LEFT      = 5'd13;
   localparam key_type KEY_HOME      = 5'd14;
   localparam key_type KEY_END       = 5'd15;
   localparam key_type KEY_F1        = 5'd16;
   localparam key_type KEY_F2        = 5'd17;
   localparam key_type KEY_F3        = 5'd18;
   localparam key_type KEY_F4        = 5'd19;
   localparam key_type KEY_F5        = 5'd20;
   localparam key_type KEY_F6        = 5'd21;
   localparam key_type KEY_F7        = 5'd22;
   localparam key_type KEY_F8        = 5'd23;
   localparam key_type KEY_F9        = 5'd24;
   localparam key_type KEY_F10       = 5'd25;
   localparam key_type KEY_F11       = 5'd26;
   localparam key_type KEY_F12       = 5'd27;
   localparam key_type KEY_LAST      = KEY_F12;

   typedef struct packed {
      key_type  key_code;
      byte_type char_value;
      mod_type  modifier_bits;
      logic     sequence_error;
   } tksd_result_type;

   // one step of the parser: result, whether it exists, and the next state, number and digit
   typedef struct packed {
      logic            emit;
      tksd_result_type result;
      state_type       state;
      byte_type        number;
      digit_type       digit;
   } tksd_step_type;

   // key table shared by CSI numbers, CSI letters and SS3 bytes; empty and out of range miss
   function automatic key_type lookup_key(byte_type idx);
      key_type k;
      k = KEY_UNKNOWN;
      if (32'(idx) < KeyTableLen) begin
         unique case (idx)
            8'd2:    k = KEY_INSERT;
            8'd3:    k = KEY_DELETE;
            8'd5:    k = KEY_PGUP;
            8'd6:    k = KEY_PGDN;
            8'd15:   k = KEY_F5;
            8'd17:   k = KEY_F6;
            8'd18:   k = KEY_F7;
            8'd19:   k = KEY_F8;
            8'd20:   k = KEY_F9;
            8'd21:   k = KEY_F10;
            8'd23:   k = KEY_F11;
            8'd24:   k = KEY_F12;
            8'd65:   k = KEY_UP;
            8'd66:   k = KEY_DOWN;
            8'd67:   k = KEY_RIGHT;
            8'd68:   k = KEY_LEFT;
            8'd70:   k = KEY_END;
            8'd72:   k = KEY_HOME;
            8'd80:   k = KEY_F1;
            8'd81:   k = KEY_F2;
            8'd82:   k = KEY_F3;
            8'd83:   k = KEY_F4;
            default: k = KEY_UNKNOWN;
         endcase
      end
      return k;
   endfunction

   // modifier digits 2..8 give shift/alt/ctrl bits, anything else none
   function automatic mod_type mod_bits(digit_type d);
      mod_type m;
      m = '0;
      if (d >= 4'd2 && d <= 4'd8) begin
         m = ModWidth'(d - 4'd1);
      end
      return m;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tksd_if.sv =====
// Valid/ready channel interfaces of the terminal key sequence decoder:
// the byte channel and the key event channel. Depends on tksd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tksd_req_if;
   logic              valid;
   logic              ready;
   tksd_pkg::byte_type byte_value;
   logic              chunk_end;

   modport source (output valid, output byte_value, output chunk_end, input ready);
   modport sink   (input valid, input byte_value, input chunk_end, output ready);
endinterface

interface tksd_rsp_if;
   logic              valid;
   logic              ready;
   tksd_pkg::key_type  key_code;
   tksd_pkg::byte_type char_value;
   tksd_pkg::mod_type  modifier_bits;
   logic              sequence_error;

   modport source (output valid, output key_code, output char_value,
                   output modifier_bits, output sequence_error, input ready);
   modport sink   (input valid, input key_code, input char_value,
                   input modifier_bits, input sequence_error, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/terminal_key_sequence_decoder.sv =====
// Terminal key sequence decoder, top level: parser state registers and the
// result register. Depends on tksd_pkg, tksd_if and tksd_decode.
//
// Usage:
//   req_chan carries one terminal byte per item plus chunk_end, which marks the
//   last byte of a read chunk. rsp_chan carries key events: key_code,
//   char_value, modifier_bits and sequence_error.
//   Each byte causes zero or one key event. A byte is decoded in the cycle it
//   is accepted and its event appears in the result register on the next
//   cycle, at a rate of one byte per cycle.
//   The rate is set by the one-deep result register: a new byte is accepted
//   whenever that register is empty or its item is taken in the same cycle,
//   so with rsp_chan.ready held high the block takes a byte every cycle.
//   When the receiver stalls with an event waiting, req_chan.ready drops and
//   the parser state holds until the event is taken.
//   Synchronous reset puts the parser in the begin state with number and
//   modifier digit cleared and empties the result register.
//   At chunk end a pending ESC gives an escape event and any other
//   unfinished sequence gives an error event; the parser then restarts.
`timescale 1ns / 1ps
`default_nettype none

module terminal_key_sequence_decoder (
   input  logic       clock,
   input  logic       reset,
   tksd_req_if.sink   req_chan,
   tksd_rsp_if.source rsp_chan
);
   import tksd_pkg::*;

   state_type       state_ff,  state_in;
   byte_type        number_ff, number_in;
   digit_type       digit_ff,  digit_in;
   logic            out_valid_ff, out_valid_in;
   tksd_result_type out_ff, out_in;
   tksd_step_type   step;
   logic            accept;

   tksd_decode u_decode (
      .state      (state_ff),
      .number     (number_ff),
      .digit      (digit_ff),
      .byte_value (req_chan.byte_value),
      .chunk_end  (req_chan.chunk_end),
      .step       (step)
   );

   assign req_chan.ready = !out_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      state_in     = state_ff;
      number_in    = number_ff;
      digit_in     = digit_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      if (accept) begin
         state_in  = step.state;
         number_in = step.number;
         digit_in  = step.digit;
         if (step.emit) begin
            out_in       = step.result;
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_BEGIN;
         number_ff    <= '0;
         digit_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         number_ff    <= number_in;
         digit_ff     <= digit_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.key_code       = out_ff.key_code;
   assign rsp_chan.char_value     = out_ff.char_value;
   assign rsp_chan.modifier_bits  = out_ff.modifier_bits;
   assign rsp_chan.sequence_error = out_ff.sequence_error;

   // a chunk end always leaves the parser cleared
   a_chunk_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.chunk_end |=>
         state_ff == ST_BEGIN && number_ff == '0 && digit_ff == '0)
      else $error("parser not cleared after chunk end");

   // the number only lives inside a CSI sequence
   a_number_scope: assert property (@(posedge clock) disable iff (reset)
      number_ff != '0 |-> state_ff == ST_CSI || state_ff == ST_MOD)
      else $error("number held outside CSI");

   // error events carry nothing else
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.sequence_error |->
         rsp_chan.key_code == KEY_UNKNOWN && rsp_chan.char_value == '0 &&
         rsp_chan.modifier_bits == '0)
      else $error("error event with payload");

   // a character value only comes with a char event, and codes stay in range
   a_char_only: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         (rsp_chan.char_value == '0 || rsp_chan.key_code == KEY_CHAR) &&
         rsp_chan.key_code <= KEY_LAST)
      else $error("bad key event fields");

   // an item accepted into a stalled result register would be lost
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready |-> !accept)
      else $error("item accepted while result stalled");

endmodule

`default_nettype wire

// ===== hw/rtl/tksd_decode.sv =====
// Combinational parser step: present state and one byte in, next state and
// at most one key event out. Depends on tksd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tksd_decode (
   input  tksd_pkg::state_type     state,
   input  tksd_pkg::byte_type      number,
   input  tksd_pkg::digit_type     digit,
   input  tksd_pkg::byte_type      byte_value,
   input  logic                    chunk_end,
   output tksd_pkg::tksd_step_type step
);
   import tksd_pkg::*;

   logic     is_digit;
   logic     is_alpha;
   logic [11:0] num_ext;
   mod_type  cur_mod;

   assign is_digit = (byte_value >= CH_ZERO) && (byte_value <= CH_NINE);
   assign is_alpha = ((byte_value >= CH_UC_A) && (byte_value <= CH_UC_Z)) ||
                     ((byte_value >= CH_LC_A) && (byte_value <= CH_LC_Z));
   assign num_ext  = 12'(number) * 12'(NumberRadix) + 12'(byte_value - CH_ZERO);
   assign cur_mod  = mod_bits(digit);

   always_comb begin
      step        = '0;
      step.state  = state;
      step.number = number;
      step.digit  = digit;

      unique case (state)
         ST_ESC: begin
            if (byte_value == CH_CSI) begin
               step.state = ST_CSI;
            end else if (byte_value == CH_SS3) begin
               step.state = ST_SS3;
            end
         end
         ST_CSI: begin
            priority if (byte_value == CH_TILDE) begin
               step.emit                 = 1'b1;
               step.result.key_code      = lookup_key(number);
               step.result.modifier_bits = cur_mod;
               step.state                = ST_BEGIN;
               step.number               = '0;
               step.digit                = '0;
            end else if (byte_value == CH_SEMI) begin
               step.state = ST_MOD;
            end else if (is_digit) begin
               // saturate the decimal number
               step.number = (num_ext > 12'(NumberMax)) ? NumberMax : num_ext[7:0];
            end else if (is_alpha) begin
               step.emit                 = 1'b1;
               step.result.key_code      = lookup_key(byte_value);
               step.result.modifier_bits = cur_mod;
               step.state                = ST_BEGIN;
               step.number               = '0;
               step.digit                = '0;
            end
         end
         ST_SS3: begin
            step.emit                 = 1'b1;
            step.result.key_code      = lookup_key(byte_value);
            step.result.modifier_bits = cur_mod;
            step.state                = ST_BEGIN;
            step.number               = '0;
            step.digit                = '0;
         end
         ST_MOD: begin
            if (is_digit) begin
               step.digit = DigitWidth'(byte_value - CH_ZERO);
               step.state = ST_CSI;
            end
         end
         default: begin
            // begin state, and the unreachable codes behave the same
            step.state  = ST_BEGIN;
            step.number = '0;
            step.digit  = '0;
            if (byte_value == CH_ESC) begin
               step.state = ST_ESC;
            end else begin
               step.emit = 1'b1;
               priority if (byte_value == CH_TAB) begin
                  step.result.key_code = KEY_TAB;
               end else if (byte_value == CH_DEL) begin
                  step.result.key_code = KEY_BACKSPACE;
               end else if (byte_value == CH_CR) begin
                  step.result.key_code = KEY_ENTER;
               end else begin
                  step.result.key_code   = KEY_CHAR;
                  step.result.char_value = byte_value;
               end
            end
         end
      endcase

      // chunk end: flush a pending sequence, then drop back to begin
      if (chunk_end) begin
         if (step.state == ST_ESC) begin
            step.emit   = 1'b1;
            step.result = '{key_code: KEY_ESCAPE, char_value: '0, modifier_bits: '0,
                            sequence_error: 1'b0};
         end else if (step.state == ST_CSI || step.state == ST_SS3 ||
                      step.state == ST_MOD) begin
            step.emit   = 1'b1;
            step.result = '{key_code: KEY_UNKNOWN, char_value: '0, modifier_bits: '0,
                            sequence_error: 1'b1};
         end
         step.state  = ST_BEGIN;
         step.number = '0;
         step.digit  = '0;
      end
   end

endmodule

`default_nettype wire
